### hdl/chip8_instruction_execute_core_macros.svh
// assertion macros for the chip8 instruction execute core
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define C8IE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c8ie assertion failed");
// next-cycle implication, checked out of reset
`define C8IE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c8ie assertion failed");
`else
`define C8IE_ASSERT_IMP(lbl, ante, cons)
`define C8IE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/c8ie_pkg.sv
// types and constants of the chip8 instruction execute core
`default_nettype none

package c8ie_pkg;

    localparam int PC_W = 12;

    typedef logic [PC_W-1:0] t_addr;

    // input transaction
    typedef struct packed {
        logic        cmd;
        logic [15:0] instruction;
    } t_in_item;

    // result transaction
    typedef struct packed {
        t_addr       next_pc;
        logic        clear_screen;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic [7:0]  flag_value;
        logic [1:0]  status;
    } t_out_item;

    // commands
    localparam logic CMD_EXEC    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_IMPL  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // major opcodes (top nibble)
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JUMP  = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SKEQ  = 4'h3;
    localparam logic [3:0] OP_SKNE  = 4'h4;
    localparam logic [3:0] OP_SKREG = 4'h5;
    localparam logic [3:0] OP_SET   = 4'h6;
    localparam logic [3:0] OP_ADD   = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;

    // system sub-opcodes
    localparam t_addr SYS_CLS = 12'h0E0;
    localparam t_addr SYS_RET = 12'h0EE;

    // alu sub-opcodes (low nibble of 8XYN)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [3:0] VF_IDX      = 4'hF;
    localparam t_addr      PC_STEP     = 12'd2;
    localparam t_addr      START_RESET = 12'd512;

endpackage

`default_nettype wire

### hdl/chip8_instruction_execute_core.sv
// top level of the chip8 instruction execute core
//
// Executes one fetched CHIP-8 instruction word per input transaction and
// returns one result transaction: next pc, clear-screen request, register X
// and its value, VF and a status code.
// Input channel: i_in_valid / o_in_stall with payload i_in_data. Output
// channel: o_out_valid / i_out_stall with payload o_out_data. A transaction
// moves at a rising edge where valid is high and stall is low.
// Start address register: written through i_cfg_valid / o_cfg_ready /
// i_cfg_data, ready is always high; write it only while the core is idle.
// From input acceptance to result valid an instruction passes the input
// register (V register and return stack reads) and then the result register.
// One instruction per cycle unless the receiver stalls; the 8-bit alu, pc
// adder and register file bypass all sit in the single stage between the two.
// When the receiver stalls, the result register holds and the input register
// holds its instruction; o_in_stall rises only when both are full.
// Reset (synchronous, active low) clears V0..VF, sets pc and the start
// address to 512, empties the return stack and drops both valid flags.
// Return stack holds STACK_DEPTH entries.
`default_nettype none
`include "chip8_instruction_execute_core_macros.svh"

module chip8_instruction_execute_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  c8ie_pkg::t_in_item   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output c8ie_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  c8ie_pkg::t_addr      i_cfg_data
);

    import c8ie_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);

    // architectural state
    logic [7:0]     r_vmem [0:15];
    logic [15:0]    r_vvalid;
    logic [7:0]     r_vf;
    logic [11:0]    r_rstack [0:STACK_DEPTH-1];
    t_addr          r_pc;
    t_addr          r_start;
    logic [SPW-1:0] r_sp;

    // input stage
    logic           r_s1_valid;
    t_in_item       r_s1_item;
    logic [7:0]     r_vx;
    logic [7:0]     r_vy;
    t_addr          r_ret;

    // result stage
    logic           r_out_valid;
    t_out_item      r_out;

    // handshake
    logic out_free;
    logic exec;
    logic in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // decode
    logic [3:0] top;
    logic [3:0] ix;
    logic [3:0] in_n;
    logic [7:0] nn;
    t_addr      nnn;

    assign top  = r_s1_item.instruction[15:12];
    assign ix   = r_s1_item.instruction[11:8];
    assign in_n = r_s1_item.instruction[3:0];
    assign nn   = r_s1_item.instruction[7:0];
    assign nnn  = r_s1_item.instruction[11:0];

    // execute
    t_addr      pc_adv;
    t_addr      n_pc_exec;
    logic       clr;
    logic [1:0] status;
    logic       vx_we;
    logic [7:0] vx_wd;
    logic       flag_we;
    logic [7:0] flag;
    logic       push;
    logic       pop;
    logic [8:0] sum9;

    assign pc_adv = r_pc + PC_STEP;
    assign sum9   = {1'b0, r_vx} + {1'b0, r_vy};

    always_comb begin
        n_pc_exec = pc_adv;
        clr       = 1'b0;
        status    = ST_OK;
        vx_we     = 1'b0;
        vx_wd     = r_vx;
        flag_we   = 1'b0;
        flag      = 8'd0;
        push      = 1'b0;
        pop       = 1'b0;
        if (r_s1_item.cmd == CMD_RESTART) begin
            n_pc_exec = r_start;
            clr       = 1'b1;
        end else begin
            unique case (top)
                OP_SYS: begin
                    if (nnn == SYS_CLS) begin
                        clr = 1'b1;
                    end else if (nnn == SYS_RET) begin
                        if (r_sp == '0) begin
                            status = ST_UNDERFLOW;
                        end else begin
                            pop       = 1'b1;
                            n_pc_exec = r_ret;
                        end
                    end else begin
                        status = ST_NOT_IMPL;
                    end
                end
                OP_JUMP: begin
                    n_pc_exec = nnn;
                end
                OP_CALL: begin
                    if (r_sp >= SPW'(STACK_DEPTH)) begin
                        status = ST_OVERFLOW;
                    end else begin
                        push      = 1'b1;
                        n_pc_exec = nnn;
                    end
                end
                OP_SKEQ: begin
                    if (r_vx == nn) n_pc_exec = pc_adv + PC_STEP;
                end
                OP_SKNE: begin
                    if (r_vx != nn) n_pc_exec = pc_adv + PC_STEP;
                end
                OP_SKREG: begin
                    if (r_vx == r_vy) n_pc_exec = pc_adv + PC_STEP;
                end
                OP_SET: begin
                    vx_we = 1'b1;
                    vx_wd = nn;
                end
                OP_ADD: begin
                    vx_we = 1'b1;
                    vx_wd = r_vx + nn;
                end
                OP_ALU: begin
                    unique case (in_n)
                        ALU_MOV: begin
                            vx_we = 1'b1;
                            vx_wd = r_vy;
                        end
                        ALU_OR: begin
                            vx_we = 1'b1;
                            vx_wd = r_vx | r_vy;
                        end
                        ALU_AND: begin
                            vx_we = 1'b1;
                            vx_wd = r_vx & r_vy;
                        end
                        ALU_XOR: begin
                            vx_we = 1'b1;
                            vx_wd = r_vx ^ r_vy;
                        end
                        ALU_ADD: begin
                            vx_we   = 1'b1;
                            vx_wd   = sum9[7:0];
                            flag_we = 1'b1;
                            flag    = {7'd0, sum9[8]};
                        end
                        ALU_SUB: begin
                            vx_we   = 1'b1;
                            vx_wd   = r_vx - r_vy;
                            flag_we = 1'b1;
                            flag    = {7'd0, (r_vx >= r_vy)};
                        end
                        ALU_SHR: begin
                            vx_we   = 1'b1;
                            vx_wd   = {1'b0, r_vx[7:1]};
                            flag_we = 1'b1;
                            flag    = {7'd0, r_vx[0]};
                        end
                        ALU_SUBN: begin
                            vx_we   = 1'b1;
                            vx_wd   = r_vy - r_vx;
                            flag_we = 1'b1;
                            flag    = {7'd0, (r_vy >= r_vx)};
                        end
                        ALU_SHL: begin
                            vx_we   = 1'b1;
                            vx_wd   = {r_vx[6:0], 1'b0};
                            flag_we = 1'b1;
                            flag    = {7'd0, r_vx[7]};
                        end
                        default: begin
                            status = ST_NOT_IMPL;
                        end
                    endcase
                end
                default: begin
                    status = ST_NOT_IMPL;
                end
            endcase
        end
    end

    // register writeback values; VF flag wins over a VX write to VF
    logic [7:0] vf_exec;
    logic [7:0] vx_after;
    logic [7:0] n_vf;
    logic       mwe;

    always_comb begin
        if (flag_we) begin
            vf_exec = flag;
        end else if (vx_we && ix == VF_IDX) begin
            vf_exec = vx_wd;
        end else begin
            vf_exec = r_vf;
        end
    end

    assign vx_after = (ix == VF_IDX) ? vf_exec : (vx_we ? vx_wd : r_vx);
    assign n_vf     = exec ? vf_exec : r_vf;
    assign mwe      = exec && vx_we && (ix != VF_IDX);

    // stack pointer update and return address read address
    logic [SPW-1:0] n_sp;
    logic [SPW-1:0] sp_dec;
    logic [SIW-1:0] rs_raddr;
    logic [SIW-1:0] rs_waddr;
    logic           swe;

    always_comb begin
        if (exec && push) begin
            n_sp = r_sp + SPW'(1);
        end else if (exec && pop) begin
            n_sp = r_sp - SPW'(1);
        end else begin
            n_sp = r_sp;
        end
    end

    assign sp_dec   = n_sp - SPW'(1);
    assign rs_raddr = sp_dec[SIW-1:0];
    assign rs_waddr = r_sp[SIW-1:0];
    assign swe      = exec && push;

    // operand bypass for the next instruction
    logic [3:0] nx;
    logic [3:0] ny;
    logic       byp_x;
    logic       byp_y;
    logic [7:0] byp_x_data;
    logic [7:0] byp_y_data;

    assign nx = i_in_data.instruction[11:8];
    assign ny = i_in_data.instruction[7:4];

    always_comb begin
        byp_x      = 1'b1;
        byp_x_data = n_vf;
        if (nx != VF_IDX) begin
            byp_x      = mwe && (ix == nx);
            byp_x_data = vx_wd;
        end
        byp_y      = 1'b1;
        byp_y_data = n_vf;
        if (ny != VF_IDX) begin
            byp_y      = mwe && (ix == ny);
            byp_y_data = vx_wd;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvalid    <= '0;
            r_vf        <= 8'd0;
            r_pc        <= START_RESET;
            r_start     <= START_RESET;
            r_sp        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_start <= i_cfg_data;
            end
            if (mwe) begin
                r_vvalid[ix] <= 1'b1;
            end
            r_vf <= n_vf;
            r_sp <= n_sp;
            if (exec) begin
                r_pc <= n_pc_exec;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (exec) begin
                r_s1_valid <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // register file and return stack memories
    always_ff @(posedge i_clk) begin
        if (mwe) begin
            r_vmem[ix] <= vx_wd;
        end
        if (swe) begin
            r_rstack[rs_waddr] <= pc_adv;
        end
    end

    // input stage capture with registered reads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in_data;
            r_vx      <= byp_x ? byp_x_data : (r_vvalid[nx] ? r_vmem[nx] : 8'd0);
            r_vy      <= byp_y ? byp_y_data : (r_vvalid[ny] ? r_vmem[ny] : 8'd0);
            r_ret     <= (swe && rs_waddr == rs_raddr) ? pc_adv : r_rstack[rs_raddr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out.next_pc      <= n_pc_exec;
            r_out.clear_screen <= clr;
            r_out.reg_index    <= ix;
            r_out.reg_value    <= vx_after;
            r_out.flag_value   <= vf_exec;
            r_out.status       <= status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `C8IE_ASSERT_NXT(a_s1_hold, r_s1_valid && !out_free, r_s1_valid && $stable(r_s1_item))
    `C8IE_ASSERT_NXT(a_push_ptr, exec && push, r_sp == $past(r_sp) + SPW'(1))
    `C8IE_ASSERT_IMP(a_sp_range, r_s1_valid, r_sp <= SPW'(STACK_DEPTH))
    `C8IE_ASSERT_NXT(a_out_load, exec, o_out_valid)

endmodule

`default_nettype wire
